// ===== rtl/core/dpc_pkg.sv =====
`default_nettype none

package dpc_pkg;

  localparam int MaxSideDef = 4096;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;
  localparam int SizeW    = 13;
  localparam int DepthW   = 16;
  localparam int CenterW  = 16;
  localparam int RecipW   = 24;
  localparam int CoordW   = 20;
  localparam int CountW   = 25;

  localparam logic [CountW-1:0] CountMax = '1;

  localparam logic [SizeW-1:0]   WidthRst  = 13'd640;
  localparam logic [SizeW-1:0]   HeightRst = 13'd480;
  localparam logic [CenterW-1:0] CxRst     = 16'd5120;
  localparam logic [CenterW-1:0] CyRst     = 16'd3840;
  localparam logic [RecipW-1:0]  RfxRst    = 24'd28926;
  localparam logic [RecipW-1:0]  RfyRst    = 24'd28926;
  localparam logic [DepthW-1:0]  NearRst   = 16'd2048;
  localparam logic [DepthW-1:0]  FarRst    = 16'd24576;

  typedef enum logic [CfgIdxW-1:0] {
    CfgImageWidth  = 3'd0,
    CfgImageHeight = 3'd1,
    CfgCenterX     = 3'd2,
    CfgCenterY     = 3'd3,
    CfgRecipFx     = 3'd4,
    CfgRecipFy     = 3'd5,
    CfgNearLimit   = 3'd6,
    CfgFarLimit    = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    StIdle,
    StMul1,
    StMul2,
    StLoad
  } state_e;

  typedef struct packed {
    logic accept;
    logic mul1;
    logic mul2;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic has_result;
    logic out_free;
  } status_t;

  function automatic logic [SizeW-1:0] eff_side(logic [SizeW-1:0] v, logic [SizeW-1:0] max_v);
    logic [SizeW-1:0] r;
    r = v;
    if (v == '0) begin
      r = SizeW'(1);
    end else if (v > max_v) begin
      r = max_v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/dpc_stream_if.sv =====
`default_nettype none

interface dpc_pixel_if;
  logic        valid;
  logic        ready;
  logic [15:0] depth_sample;
  logic        sample_ok;

  modport source (output valid, output depth_sample, output sample_ok, input ready);
  modport sink (input valid, input depth_sample, input sample_ok, output ready);
endinterface

interface dpc_point_if;
  logic               valid;
  logic               ready;
  logic signed [19:0] point_x;
  logic signed [19:0] point_y;
  logic [15:0]        point_z;
  logic               point_kept;
  logic               frame_end;
  logic [24:0]        points_so_far;

  modport source (output valid, output point_x, output point_y, output point_z,
                  output point_kept, output frame_end, output points_so_far, input ready);
  modport sink (input valid, input point_x, input point_y, input point_z,
                input point_kept, input frame_end, input points_so_far, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/dpc_ctrl.sv =====
`default_nettype none

module dpc_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire dpc_pkg::status_t status_i,
  output dpc_pkg::cmd_t         cmd_o
);
  import dpc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i && status_i.has_result) begin
          state_d = StMul1;
        end
      end
      StMul1: state_d = StMul2;
      StMul2: state_d = StLoad;
      StLoad: begin
        if (status_i.out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      StIdle: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      StMul1: cmd_o.mul1 = 1'b1;
      StMul2: cmd_o.mul2 = 1'b1;
      StLoad: cmd_o.load = status_i.out_free;
      default: cmd_o = '0;
    endcase
  end

`ifndef SYNTH
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> status_i.out_free)
    else $error("result loaded while the output register is still full");
  a_mul_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mul1 |=> cmd_o.mul2)
    else $error("second multiply step did not follow the first");
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |-> in_ready_o && state_q == StIdle)
    else $error("pixel accepted outside idle");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/dpc_datapath.sv =====
`default_nettype none

module dpc_datapath #(
  parameter int MaxSide = dpc_pkg::MaxSideDef
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [dpc_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  wire logic [dpc_pkg::CfgDataW-1:0]         cfg_data_i,
  input  wire logic [dpc_pkg::DepthW-1:0]           depth_sample_i,
  input  wire logic                                 sample_ok_i,
  input  wire dpc_pkg::cmd_t                        cmd_i,
  output dpc_pkg::status_t                          status_o,
  input  wire logic                                 out_ready_i,
  output logic                                      out_valid_o,
  output logic signed [dpc_pkg::CoordW-1:0]         point_x_o,
  output logic signed [dpc_pkg::CoordW-1:0]         point_y_o,
  output logic [dpc_pkg::DepthW-1:0]                point_z_o,
  output logic                                      point_kept_o,
  output logic                                      frame_end_o,
  output logic [dpc_pkg::CountW-1:0]                points_so_far_o
);
  import dpc_pkg::*;

  localparam int CW    = $clog2(MaxSide);
  localparam int OffW  = CenterW + 1;
  localparam int MagW  = CenterW;
  localparam int P1W   = DepthW + RecipW;
  localparam int P2W   = P1W + MagW;

  logic [SizeW-1:0]   width_q, height_q;
  logic [CenterW-1:0] cx_q, cy_q;
  logic [RecipW-1:0]  rfx_q, rfy_q;
  logic [DepthW-1:0]  near_q, far_q;

  logic [CW-1:0]      col_q, row_q;
  logic [CountW-1:0]  kc_q;

  logic [DepthW-1:0]  z_q;
  logic               kept_q, fend_q;
  logic [CountW-1:0]  cnt_q;
  logic               negx_q, negy_q;
  logic [MagW-1:0]    magx_q, magy_q;
  logic [P1W-1:0]     p1x_q, p1y_q;
  logic [P2W-1:0]     p2x_q, p2y_q;

  logic               out_valid_q;
  logic [CoordW-1:0]  out_x_q, out_y_q;
  logic [DepthW-1:0]  out_z_q;
  logic               out_kept_q, out_fend_q;
  logic [CountW-1:0]  out_cnt_q;

  logic [SizeW-1:0]   last_col, last_row;
  logic               row_end, frame_end, kept;
  logic [CountW-1:0]  kc_inc;
  logic [OffW-1:0]    offx, offy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthRst;
      height_q <= HeightRst;
      cx_q     <= CxRst;
      cy_q     <= CyRst;
      rfx_q    <= RfxRst;
      rfy_q    <= RfyRst;
      near_q   <= NearRst;
      far_q    <= FarRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgImageWidth:  width_q  <= cfg_data_i[SizeW-1:0];
        CfgImageHeight: height_q <= cfg_data_i[SizeW-1:0];
        CfgCenterX:     cx_q     <= cfg_data_i[CenterW-1:0];
        CfgCenterY:     cy_q     <= cfg_data_i[CenterW-1:0];
        CfgRecipFx:     rfx_q    <= cfg_data_i[RecipW-1:0];
        CfgRecipFy:     rfy_q    <= cfg_data_i[RecipW-1:0];
        CfgNearLimit:   near_q   <= cfg_data_i[DepthW-1:0];
        CfgFarLimit:    far_q    <= cfg_data_i[DepthW-1:0];
        default: ;
      endcase
    end
  end

  assign last_col  = eff_side(width_q, SizeW'(MaxSide)) - SizeW'(1);
  assign last_row  = eff_side(height_q, SizeW'(MaxSide)) - SizeW'(1);
  assign row_end   = SizeW'(col_q) >= last_col;
  assign frame_end = row_end && (SizeW'(row_q) >= last_row);
  assign kept      = sample_ok_i && (depth_sample_i > near_q) && (depth_sample_i < far_q);
  assign kc_inc    = (kept && kc_q < CountMax) ? kc_q + CountW'(1) : kc_q;

  assign offx = OffW'({col_q, 4'b0000}) - OffW'(cx_q);
  assign offy = OffW'({row_q, 4'b0000}) - OffW'(cy_q);

  assign status_o.has_result = kept || frame_end;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      kc_q  <= '0;
    end else if (cmd_i.accept) begin
      if (frame_end) begin
        col_q <= '0;
        row_q <= '0;
        kc_q  <= '0;
      end else if (row_end) begin
        col_q <= '0;
        row_q <= row_q + CW'(1);
        kc_q  <= kc_inc;
      end else begin
        col_q <= col_q + CW'(1);
        kc_q  <= kc_inc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      z_q    <= depth_sample_i;
      kept_q <= kept;
      fend_q <= frame_end;
      cnt_q  <= kc_inc;
      negx_q <= offx[OffW-1];
      negy_q <= offy[OffW-1];
      magx_q <= offx[OffW-1] ? MagW'(-offx) : offx[MagW-1:0];
      magy_q <= offy[OffW-1] ? MagW'(-offy) : offy[MagW-1:0];
    end
    if (cmd_i.mul1) begin
      p1x_q <= P1W'(z_q) * P1W'(rfx_q);
      p1y_q <= P1W'(z_q) * P1W'(rfy_q);
    end
    if (cmd_i.mul2) begin
      p2x_q <= P2W'(p1x_q) * P2W'(magx_q);
      p2y_q <= P2W'(p1y_q) * P2W'(magy_q);
    end
  end

  // Drop 28 fraction bits of the magnitude, rounding half away from zero, then
  // apply the sign and clamp to the signed 20-bit range.
  function automatic logic [CoordW-1:0] round_sat(logic [P2W-1:0] p, logic neg);
    logic [P2W:0]      s;
    logic [P2W-28:0]   r;
    logic [P2W-28:0]   nr;
    logic [CoordW-1:0] v;
    s  = {1'b0, p} + ((P2W+1)'(1) << 27);
    r  = s[P2W:28];
    nr = -r;
    if (neg) begin
      v = (r > (P2W-27)'(524288)) ? {1'b1, {(CoordW-1){1'b0}}} : nr[CoordW-1:0];
    end else begin
      v = (r > (P2W-27)'(524287)) ? {1'b0, {(CoordW-1){1'b1}}} : r[CoordW-1:0];
    end
    return v;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_x_q    <= kept_q ? round_sat(p2x_q, negx_q) : '0;
      out_y_q    <= kept_q ? round_sat(p2y_q, negy_q) : '0;
      out_z_q    <= kept_q ? z_q : '0;
      out_kept_q <= kept_q;
      out_fend_q <= fend_q;
      out_cnt_q  <= cnt_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign point_x_o       = out_x_q;
  assign point_y_o       = out_y_q;
  assign point_z_o       = out_z_q;
  assign point_kept_o    = out_kept_q;
  assign frame_end_o     = out_fend_q;
  assign points_so_far_o = out_cnt_q;

`ifndef SYNTH
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> out_valid_q)
    else $error("loaded result not presented");
  a_kept_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_kept_q |-> out_cnt_q != '0)
    else $error("kept point with a zero point count");
  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept && frame_end |=> col_q == '0 && row_q == '0 && kc_q == '0)
    else $error("counters not cleared after the last pixel of a frame");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/depth_to_point_cloud.sv =====
// Depth image to point cloud back-projection.
// Pixels arrive in raster order on the pixel channel, one beat per pixel;
// the block keeps its own column and row counters against the configured
// image size. A pixel flagged as a number and lying strictly between the
// near and far limits becomes a point on the point channel, carrying the
// running count of kept points in the frame. The last pixel of a frame
// always yields a beat, marked frame_end, and restarts the counters.
// Dropped pixels are taken in idle and leave the block ready for the next
// one. A pixel that yields a beat goes through two multiply steps (depth
// times reciprocal focal length, then times pixel offset), then
// round/saturate into the output register. The next pixel can be accepted
// no sooner than the cycle after the load.
// When the receiver stalls, the result waits in the output register and
// the block holds in its load step until the register frees up.
// Reset restores the default configuration, clears the counters and
// empties the output register. Configuration writes take effect at once.
`default_nettype none

module depth_to_point_cloud #(
  parameter int MaxSide = dpc_pkg::MaxSideDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [dpc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [dpc_pkg::CfgDataW-1:0] cfg_data_i,
  dpc_pixel_if.sink                         in_ch,
  dpc_point_if.source                       out_ch
);
  import dpc_pkg::*;

  cmd_t    cmd;
  status_t status;

  dpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dpc_datapath #(
    .MaxSide (MaxSide)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .depth_sample_i  (in_ch.depth_sample),
    .sample_ok_i     (in_ch.sample_ok),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_ready_i     (out_ch.ready),
    .out_valid_o     (out_ch.valid),
    .point_x_o       (out_ch.point_x),
    .point_y_o       (out_ch.point_y),
    .point_z_o       (out_ch.point_z),
    .point_kept_o    (out_ch.point_kept),
    .frame_end_o     (out_ch.frame_end),
    .points_so_far_o (out_ch.points_so_far)
  );

endmodule

`default_nettype wire

// ===== sim/tb_depth_to_point_cloud.sv =====
`default_nettype none

module tb_depth_to_point_cloud;
  import dpc_pkg::*;

  localparam int IdlePct     = 38;
  localparam int RandomItems = 1350;
  localparam int DrainCycles = 10;
  localparam int StallLimit  = 2000;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [DepthW-1:0]        z;
    logic                     kept;
    logic                     frame_end;
    logic [CountW-1:0]        points_so_far;
  } point_t;

  class backprojector;
    logic [SizeW-1:0]   width, height;
    logic [CenterW-1:0] cx, cy;
    logic [RecipW-1:0]  rfx, rfy;
    logic [DepthW-1:0]  near_lim, far_lim;
    logic [11:0]        col, row;
    logic [CountW-1:0]  kept_cnt;
    point_t             expected_points[$];
    int                 errors;

    function new();
      width    = WidthRst;
      height   = HeightRst;
      cx       = CxRst;
      cy       = CyRst;
      rfx      = RfxRst;
      rfy      = RfyRst;
      near_lim = NearRst;
      far_lim  = FarRst;
      col      = '0;
      row      = '0;
      kept_cnt = '0;
      errors   = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CfgDataW-1:0] v);
      case (idx)
        CfgImageWidth:  width    = v[SizeW-1:0];
        CfgImageHeight: height   = v[SizeW-1:0];
        CfgCenterX:     cx       = v[CenterW-1:0];
        CfgCenterY:     cy       = v[CenterW-1:0];
        CfgRecipFx:     rfx      = v[RecipW-1:0];
        CfgRecipFy:     rfy      = v[RecipW-1:0];
        CfgNearLimit:   near_lim = v[DepthW-1:0];
        CfgFarLimit:    far_lim  = v[DepthW-1:0];
        default: ;
      endcase
    endfunction

    function int clamp_side(logic [SizeW-1:0] v);
      if (v == '0) return 1;
      if (int'(v) > MaxSideDef) return MaxSideDef;
      return int'(v);
    endfunction

    function logic [CoordW-1:0] project(logic [DepthW-1:0] z, logic [RecipW-1:0] recip,
                                        logic [11:0] pos, logic [CenterW-1:0] center);
      longint          off;
      bit              neg;
      longint unsigned mag, prod, r;
      longint          v;
      off  = longint'(pos) * 16 - longint'(center);
      neg  = off < 0;
      mag  = neg ? -off : off;
      prod = 64'(z) * 64'(recip) * mag;
      r    = (prod + (64'd1 << 27)) >> 28;
      if (neg) begin
        if (r > 64'd524288) v = -524288;
        else v = -longint'(r);
      end else begin
        if (r > 64'd524287) v = 524287;
        else v = longint'(r);
      end
      return v[CoordW-1:0];
    endfunction

    function void take_pixel(logic [DepthW-1:0] z, logic ok);
      bit     row_end, last, kept;
      point_t p;
      row_end = int'(col) >= clamp_side(width) - 1;
      last    = row_end && (int'(row) >= clamp_side(height) - 1);
      kept    = ok && (z > near_lim) && (z < far_lim);
      if (kept && kept_cnt != CountMax) kept_cnt = kept_cnt + 1'b1;
      if (kept || last) begin
        p = '0;
        if (kept) begin
          p.x = project(z, rfx, col, cx);
          p.y = project(z, rfy, row, cy);
          p.z = z;
        end
        p.kept          = kept;
        p.frame_end     = last;
        p.points_so_far = kept_cnt;
        expected_points = {expected_points, p};
      end
      if (last) begin
        col      = '0;
        row      = '0;
        kept_cnt = '0;
      end else if (row_end) begin
        col = '0;
        row = row + 1'b1;
      end else begin
        col = col + 1'b1;
      end
    endfunction

    function void check_point(point_t got);
      point_t want;
      if (expected_points.size() == 0) begin
        $error("point beat with no expected point: x %0d y %0d z %0d", got.x, got.y, got.z);
        errors++;
        return;
      end
      want = expected_points.pop_front();
      if (got.x !== want.x) begin
        $error("point_x: expected %0d, actual %0d", want.x, got.x);
        errors++;
      end
      if (got.y !== want.y) begin
        $error("point_y: expected %0d, actual %0d", want.y, got.y);
        errors++;
      end
      if (got.z !== want.z) begin
        $error("point_z: expected %0d, actual %0d", want.z, got.z);
        errors++;
      end
      if (got.kept !== want.kept) begin
        $error("point_kept: expected %0d, actual %0d", want.kept, got.kept);
        errors++;
      end
      if (got.frame_end !== want.frame_end) begin
        $error("frame_end: expected %0d, actual %0d", want.frame_end, got.frame_end);
        errors++;
      end
      if (got.points_so_far !== want.points_so_far) begin
        $error("points_so_far: expected %0d, actual %0d", want.points_so_far,
               got.points_so_far);
        errors++;
      end
    endfunction

    function int pending();
      return expected_points.size();
    endfunction
  endclass

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                cfg_we     = 1'b0;
  cfg_idx_e            cfg_idx    = CfgImageWidth;
  logic [CfgDataW-1:0] cfg_data   = '0;
  logic                sink_ready = 1'b0;
  bit                  calm       = 1'b0;
  int                  idle_cycles = 0;
  point_t              seen_point;
  backprojector        sb;

  logic [SizeW-1:0]   cur_w    = WidthRst;
  logic [SizeW-1:0]   cur_h    = HeightRst;
  logic [CenterW-1:0] cur_cx   = CxRst;
  logic [CenterW-1:0] cur_cy   = CyRst;
  logic [RecipW-1:0]  cur_rfx  = RfxRst;
  logic [RecipW-1:0]  cur_rfy  = RfyRst;
  logic [DepthW-1:0]  cur_near = NearRst;
  logic [DepthW-1:0]  cur_far  = FarRst;

  dpc_pixel_if pix ();
  dpc_point_if pts ();

  assign pts.ready = sink_ready;

  depth_to_point_cloud dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_ch      (pix.sink),
    .out_ch     (pts.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    sink_ready <= calm || ($urandom_range(0, 99) >= IdlePct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && pts.valid && pts.ready) begin
      seen_point.x             = pts.point_x;
      seen_point.y             = pts.point_y;
      seen_point.z             = pts.point_z;
      seen_point.kept          = pts.point_kept;
      seen_point.frame_end     = pts.frame_end;
      seen_point.points_so_far = pts.points_so_far;
      sb.check_point(seen_point);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (pix.valid && pix.ready) || (pts.valid && pts.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [DepthW-1:0] pick_depth();
    int r, lo, hi;
    r  = $urandom_range(0, 99);
    lo = int'(cur_near);
    hi = int'(cur_far);
    if (r < 70 && hi > lo + 1) return DepthW'($urandom_range(lo + 1, hi - 1));
    if (r < 85) begin
      case ($urandom_range(0, 3))
        0: return '0;
        1: return '1;
        2: return cur_near;
        default: return cur_far;
      endcase
    end
    return DepthW'($urandom());
  endfunction

  function automatic logic [CenterW-1:0] pick_center();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return CenterW'($urandom());
      default: return CenterW'($urandom_range(0, 160));
    endcase
  endfunction

  function automatic logic [RecipW-1:0] pick_recip();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return RecipW'($urandom());
      default: return RecipW'($urandom_range(1000, 200000));
    endcase
  endfunction

  function automatic void randomize_config();
    int n;
    case ($urandom_range(0, 19))
      0: cur_w = '0;
      1: cur_w = SizeW'(MaxSideDef);
      2: cur_w = '1;
      3: cur_w = SizeW'($urandom_range(9, 64));
      default: cur_w = SizeW'($urandom_range(1, 8));
    endcase
    case ($urandom_range(0, 19))
      0: cur_h = '0;
      1: cur_h = '1;
      2: cur_h = SizeW'($urandom_range(7, 40));
      default: cur_h = SizeW'($urandom_range(1, 6));
    endcase
    cur_cx  = pick_center();
    cur_cy  = pick_center();
    cur_rfx = pick_recip();
    cur_rfy = pick_recip();
    case ($urandom_range(0, 9))
      0: begin
        cur_near = DepthW'($urandom());
        cur_far  = cur_near;
      end
      1: begin
        n        = $urandom_range(1, 65535);
        cur_near = DepthW'(n);
        cur_far  = DepthW'($urandom_range(0, n - 1));
      end
      2: begin
        cur_near = '0;
        cur_far  = '1;
      end
      default: begin
        n        = $urandom_range(0, 20000);
        cur_near = DepthW'(n);
        cur_far  = DepthW'($urandom_range(n + 1, 65535));
      end
    endcase
  endfunction

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] v);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= v;
    @(posedge clk_i);
    sb.set_reg(idx, v);
  endtask

  task automatic apply_config();
    pix.valid <= 1'b0;
    wait_drained();
    write_reg(CfgImageWidth,  CfgDataW'(cur_w));
    write_reg(CfgImageHeight, CfgDataW'(cur_h));
    write_reg(CfgCenterX,     CfgDataW'(cur_cx));
    write_reg(CfgCenterY,     CfgDataW'(cur_cy));
    write_reg(CfgRecipFx,     CfgDataW'(cur_rfx));
    write_reg(CfgRecipFy,     CfgDataW'(cur_rfy));
    write_reg(CfgNearLimit,   CfgDataW'(cur_near));
    write_reg(CfgFarLimit,    CfgDataW'(cur_far));
    cfg_we <= 1'b0;
  endtask

  task automatic send_pixel(logic [DepthW-1:0] depth, logic ok);
    while (!calm && $urandom_range(0, 99) < IdlePct) begin
      pix.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix.valid        <= 1'b1;
    pix.depth_sample <= depth;
    pix.sample_ok    <= ok;
    do @(posedge clk_i); while (pix.ready !== 1'b1);
    sb.take_pixel(depth, ok);
  endtask

  task automatic send_random_pixel();
    send_pixel(pick_depth(), $urandom_range(0, 99) < 85);
  endtask

  // Starts from a fresh frame so that the counters sweep the whole size.
  task automatic run_full_frame(logic [SizeW-1:0] w, logic [SizeW-1:0] h, int pixels);
    randomize_config();
    cur_w = SizeW'(1);
    cur_h = SizeW'(1);
    apply_config();
    send_random_pixel();
    cur_w = w;
    cur_h = h;
    apply_config();
    repeat (pixels) send_random_pixel();
  endtask

  initial begin
    int sent, phase, len;
    sb = new();
    pix.valid        <= 1'b0;
    pix.depth_sample <= '0;
    pix.sample_ok    <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_pixel(16'd0, 1'b1);
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(NearRst, 1'b1);
    send_pixel(NearRst + 16'd1, 1'b1);
    send_pixel(FarRst - 16'd1, 1'b1);
    send_pixel(FarRst, 1'b1);
    send_pixel(16'd10000, 1'b0);
    send_pixel(16'd10000, 1'b1);

    // Shrinking the image below the current column ends the frame at once.
    cur_w = SizeW'(2);
    cur_h = SizeW'(1);
    apply_config();
    send_pixel(16'hFFFF, 1'b0);

    cur_near = 16'd30000;
    cur_far  = 16'd1000;
    apply_config();
    send_pixel(16'd15000, 1'b1);
    send_pixel(16'd20000, 1'b1);

    cur_near = '0;
    cur_far  = '1;
    cur_rfx  = '0;
    cur_rfy  = '0;
    apply_config();
    send_pixel(16'hFFFE, 1'b1);
    send_pixel(16'd1, 1'b1);

    cur_rfx = '1;
    cur_rfy = '1;
    cur_cx  = '1;
    cur_cy  = '1;
    apply_config();
    send_pixel(16'hFFFE, 1'b1);
    send_pixel(16'hFFFE, 1'b1);

    run_full_frame('0, SizeW'(6), 12);
    run_full_frame(SizeW'(9), '0, 18);

    sent  = 0;
    phase = 0;
    while (sent < RandomItems) begin
      randomize_config();
      apply_config();
      calm = (phase == 3);
      len  = calm ? 300 : $urandom_range(15, 70);
      repeat (len) send_random_pixel();
      calm  = 1'b0;
      sent += len;
      phase++;
    end

    pix.valid <= 1'b0;
    wait_drained();
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
